// File: hw/rtl/fed_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the feedback echo delay block.
// No dependencies; used by the channel interfaces and the top level.
package fed_pkg;

    typedef logic signed [15:0] sample_t;
    typedef logic [1:0]         cfg_index_t;
    typedef logic [15:0]        cfg_data_t;

    // Configuration register indexes.
    localparam cfg_index_t CFG_DELAY_FRAMES  = 2'd0;
    localparam cfg_index_t CFG_FEEDBACK_GAIN = 2'd1;
    localparam cfg_index_t CFG_WET_MIX       = 2'd2;
    localparam cfg_index_t CFG_CHANNEL_COUNT = 2'd3;

    // Register reset values.
    localparam logic [15:0] DELAY_RESET    = 16'd4800;
    localparam logic [14:0] FEEDBACK_RESET = 15'd0;
    localparam logic [15:0] WET_RESET      = 16'd16384;
    localparam logic [1:0]  CHANNELS_RESET = 2'd2;

    // Feedback is held at 0.95 in Q0.15 and the wet share at unity in Q1.15.
    localparam logic [14:0] FEEDBACK_CAP = 15'd31129;
    localparam logic [15:0] UNITY_Q15    = 16'd32768;

    // Width of the wide accumulations and the rounding offset before the shift.
    localparam int ACC_W = 34;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 34'sd16384;

    // Clamp a wide signed value into a 16-bit sample.
    function automatic sample_t sat16(input logic signed [ACC_W-1:0] v);
        sample_t r;
        if (v > 34'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -34'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/fed_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the input samples and the mixed results.
// Depends on fed_pkg for the sample type.
interface fed_in_if;
    logic             valid;
    logic             ready;
    fed_pkg::sample_t sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface fed_out_if;
    logic             valid;
    logic             ready;
    fed_pkg::sample_t sample_out;
    logic             channel_index;

    modport source (output valid, output sample_out, output channel_index, input ready);
    modport sink   (input valid, input sample_out, input channel_index, output ready);
endinterface

// File: hw/rtl/feedback_echo_delay_core.sv
`timescale 1ns / 1ps
// Feedback echo delay with dry/wet mix over interleaved audio, echo line in one RAM.
// Depends on fed_pkg, fed_if (fed_in_if, fed_out_if) and fed_ram.
//
//   Port      Dir   Payload                       Beat taken when
//   samples   in    sample_in (Q1.15)             samples.valid && samples.ready
//   mixed     out   sample_out, channel_index     mixed.valid && mixed.ready
//   cfg_*     in    cfg_index, cfg_data           cfg_we
//
// One sample per cycle sustained while mixed.ready holds; a taken beat passes stage 1, stage 2 and the output register.
// The rate is set by the echo RAM: one read and one write per cycle.
// After reset a clearing pass zeroes all FRAME_CAPACITY * MAX_CHANNELS RAM words
// (131072 at the defaults), with samples.ready low; configuration is taken as usual.
// A stalled output beat holds in place while the earlier stages still fill their bubbles.
module feedback_echo_delay_core #(
    parameter int FRAME_CAPACITY = 65536,
    parameter int MAX_CHANNELS   = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    fed_in_if.sink                samples,
    fed_out_if.source             mixed,
    input  logic                  cfg_we,
    input  fed_pkg::cfg_index_t   cfg_index,
    input  fed_pkg::cfg_data_t    cfg_data
);

    localparam int DEPTH = FRAME_CAPACITY * MAX_CHANNELS;
    localparam int FW    = $clog2(FRAME_CAPACITY);
    localparam int FW1   = FW + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int DCW   = (FW > 16) ? FW : 16;

    // ---------------- configuration ----------------
    logic [15:0] delay_reg;
    logic [14:0] feedback_reg;
    logic [15:0] wet_reg;
    logic [1:0]  chans_reg;

    // ---------------- position state ----------------
    logic [FW-1:0] wf_reg, wf_next;
    logic [CW-1:0] ch_reg, ch_next;

    // ---------------- clearing pass ----------------
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    // ---------------- pipeline ----------------
    logic             s1_valid_reg;
    fed_pkg::sample_t s1_x_reg;
    logic             s1_ch_reg;
    logic [AW-1:0]    s1_raddr_reg;
    logic [AW-1:0]    s1_waddr_reg;
    logic             s1_ovr_valid_reg;
    fed_pkg::sample_t s1_ovr_data_reg;

    logic                     s2_valid_reg;
    fed_pkg::sample_t         s2_x_reg;
    logic                     s2_ch_reg;
    logic [AW-1:0]            s2_waddr_reg;
    logic signed [31:0]       s2_pfb_reg;
    logic signed [32:0]       s2_pdry_reg;
    logic signed [32:0]       s2_pwet_reg;

    logic             out_valid_reg;
    fed_pkg::sample_t out_sample_reg;
    logic             out_ch_reg;

    // ---------------- effective settings ----------------
    logic [DCW-1:0] d_wide;
    logic [FW-1:0]  d_eff;
    logic [3:0]     chans_eff;
    logic [14:0]    fb_eff;
    logic [15:0]    wet_eff;
    logic [16:0]    dry_eff;

    always_comb
    begin
        d_wide = DCW'(delay_reg);
        if (d_wide == '0)
        begin
            d_wide = DCW'(1);
        end
        else if (d_wide > DCW'(FRAME_CAPACITY - 1))
        begin
            d_wide = DCW'(FRAME_CAPACITY - 1);
        end
        d_eff = FW'(d_wide);

        chans_eff = {2'b00, chans_reg};
        if (chans_eff == 4'd0)
        begin
            chans_eff = 4'd1;
        end
        else if (chans_eff > 4'(MAX_CHANNELS))
        begin
            chans_eff = 4'(MAX_CHANNELS);
        end

        fb_eff  = (feedback_reg > fed_pkg::FEEDBACK_CAP) ? fed_pkg::FEEDBACK_CAP : feedback_reg;
        wet_eff = (wet_reg > fed_pkg::UNITY_Q15) ? fed_pkg::UNITY_Q15 : wet_reg;
        dry_eff = {1'b0, fed_pkg::UNITY_Q15} - {1'b0, wet_eff};
    end

    // ---------------- handshake ----------------
    logic out_adv, s2_adv, s1_adv, accept, item_wr;

    assign out_adv       = !out_valid_reg || mixed.ready;
    assign s2_adv        = !s2_valid_reg || out_adv;
    assign s1_adv        = !s1_valid_reg || s2_adv;
    assign samples.ready = s1_adv && !clr_active_reg;
    assign accept        = samples.valid && samples.ready;
    assign item_wr       = s2_valid_reg && out_adv;

    // ---------------- addresses for the incoming beat ----------------
    logic [CW-1:0] ch_use;
    logic [FW-1:0] rf;
    logic [AW-1:0] rd_addr, wr_addr_new;
    logic [3:0]    ch_inc;

    always_comb
    begin
        ch_use = (4'(ch_reg) >= chans_eff) ? '0 : ch_reg;
        if (wf_reg >= d_eff)
        begin
            rf = wf_reg - d_eff;
        end
        else
        begin
            rf = FW'(FW1'(FRAME_CAPACITY) - FW1'(d_eff - wf_reg));
        end
        rd_addr     = AW'(rf) * AW'(MAX_CHANNELS) + AW'(ch_use);
        wr_addr_new = AW'(wf_reg) * AW'(MAX_CHANNELS) + AW'(ch_use);

        ch_inc  = 4'(ch_use) + 4'd1;
        ch_next = CW'(ch_inc);
        wf_next = wf_reg;
        if (ch_inc >= chans_eff)
        begin
            ch_next = '0;
            wf_next = (wf_reg == FW'(FRAME_CAPACITY - 1)) ? '0 : wf_reg + FW'(1);
        end
    end

    // ---------------- echo RAM ----------------
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    fed_pkg::sample_t ram_wdata;
    fed_pkg::sample_t ram_rdata;
    fed_pkg::sample_t stored_sat;

    assign ram_we    = clr_active_reg || item_wr;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s2_waddr_reg;
    assign ram_wdata = clr_active_reg ? '0 : stored_sat;

    fed_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_echo_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // ---------------- stage 1: echo select and products ----------------
    // The beat in stage 2 writes after this beat's read was issued, so its value wins;
    // a write that landed on the read edge itself was caught in the override register.
    fed_pkg::sample_t echo;

    always_comb
    begin
        if (s2_valid_reg && s2_waddr_reg == s1_raddr_reg)
        begin
            echo = stored_sat;
        end
        else if (s1_ovr_valid_reg)
        begin
            echo = s1_ovr_data_reg;
        end
        else
        begin
            echo = ram_rdata;
        end
    end

    // ---------------- stage 2: round, saturate ----------------
    logic signed [fed_pkg::ACC_W-1:0] stored_full, mixed_full;

    always_comb
    begin
        stored_full = fed_pkg::ACC_W'(s2_x_reg)
                    + ((fed_pkg::ACC_W'(s2_pfb_reg) + fed_pkg::ROUND_HALF) >>> 15);
        mixed_full  = (fed_pkg::ACC_W'(s2_pdry_reg) + fed_pkg::ACC_W'(s2_pwet_reg)
                    + fed_pkg::ROUND_HALF) >>> 15;
        stored_sat  = fed_pkg::sat16(stored_full);
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg      <= fed_pkg::DELAY_RESET;
            feedback_reg   <= fed_pkg::FEEDBACK_RESET;
            wet_reg        <= fed_pkg::WET_RESET;
            chans_reg      <= fed_pkg::CHANNELS_RESET;
            wf_reg         <= '0;
            ch_reg         <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wf_reg <= wf_next;
                ch_reg <= ch_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fed_pkg::CFG_DELAY_FRAMES:  delay_reg    <= cfg_data;
                    fed_pkg::CFG_FEEDBACK_GAIN: feedback_reg <= cfg_data[14:0];
                    fed_pkg::CFG_WET_MIX:       wet_reg      <= cfg_data;
                    fed_pkg::CFG_CHANNEL_COUNT:
                    begin
                        chans_reg <= cfg_data[1:0];
                        ch_reg    <= '0;
                    end
                    default: ;
                endcase
            end
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (s1_adv)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg         <= samples.sample_in;
            s1_ch_reg        <= ch_use[0];
            s1_raddr_reg     <= rd_addr;
            s1_waddr_reg     <= wr_addr_new;
            s1_ovr_valid_reg <= item_wr && (s2_waddr_reg == rd_addr);
            s1_ovr_data_reg  <= stored_sat;
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_x_reg     <= s1_x_reg;
            s2_ch_reg    <= s1_ch_reg;
            s2_waddr_reg <= s1_waddr_reg;
            s2_pfb_reg   <= echo * $signed({1'b0, fb_eff});
            s2_pdry_reg  <= s1_x_reg * $signed(dry_eff);
            s2_pwet_reg  <= echo * $signed({1'b0, wet_eff});
        end
        if (out_adv && s2_valid_reg)
        begin
            out_sample_reg <= fed_pkg::sat16(mixed_full);
            out_ch_reg     <= s2_ch_reg;
        end
    end

    assign mixed.valid         = out_valid_reg;
    assign mixed.sample_out    = out_sample_reg;
    assign mixed.channel_index = out_ch_reg;

    // ---------------- assertions ----------------
    // The clearing pass owns the write port; no sample write may overlap it.
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !item_wr)
        else $error("sample write during clearing pass");

    // The channel counter never reaches the effective channel count.
    assert property (@(posedge clk) disable iff (!rst_n)
        4'(ch_reg) < chans_eff)
        else $error("channel counter out of range");

    // A taken beat always occupies stage 1 on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted beat lost before stage 1");

endmodule

// File: hw/rtl/fed_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port and one read port with registered data.
// A read at the address being written returns the old contents. No dependencies.
module fed_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
